>>> sv/cabn_pkg.sv
// shared types and constants for the class-aware box nms unit
// no dependencies
package cabn_pkg;

    localparam int MAX_BOXES = 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam logic [15:0] THR_RESET = 16'd29491;

    typedef struct packed {
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic [14:0]        box_width;
        logic [14:0]        box_height;
        logic [15:0]        confidence;
        logic [7:0]         class_id;
        logic               last_box;
    } t_item;

    typedef struct packed {
        logic [5:0] kept_index;
        logic       last_kept;
        logic       overflow;
    } t_result;

    // one stored box as it travels along the chain
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [15:0]        score;
        logic [7:0]         cls;
        logic [IDX_W-1:0]   idx;
        logic               keep;
    } t_box;

    typedef struct packed {
        logic load;
        logic pop;
        logic push;
    } t_cell_ctl;

endpackage

>>> sv/cabn_cell.sv
// one cell of the box chain: holds a box, sorted insert on load, returned box on push, shift on pop
// depends on cabn_pkg
module cabn_cell (
    input  logic              i_clk,
    input  cabn_pkg::t_cell_ctl i_ctl,
    input  logic              i_push_here,
    input  logic              i_vacant,
    input  logic              i_left_lt,
    input  cabn_pkg::t_box    i_left,
    input  cabn_pkg::t_box    i_right,
    input  cabn_pkg::t_box    i_new,
    input  cabn_pkg::t_box    i_ret,
    output cabn_pkg::t_box    o_box,
    output logic              o_lt
);
    cabn_pkg::t_box r_box;
    cabn_pkg::t_box n_box;

    // vacant cells count as lower so a new item lands at the tail
    assign o_lt  = i_vacant || (r_box.score < i_new.score);
    assign o_box = r_box;

    always_comb begin
        n_box = r_box;
        if (i_ctl.load && o_lt) begin
            n_box = i_left_lt ? i_left : i_new;
        end else if (i_ctl.push && i_push_here) begin
            n_box = i_ret;
        end else if (i_ctl.pop) begin
            n_box = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_box <= n_box;
    end
endmodule

>>> sv/cabn_iou.sv
// four-stage iou test of one chain box against the current kept box
// depends on cabn_pkg
module cabn_iou (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cabn_pkg::t_box i_box,
    input  cabn_pkg::t_box i_cur,
    input  logic [29:0]    i_cur_area,
    input  logic [15:0]    i_thr,
    output logic           o_valid,
    output cabn_pkg::t_box o_box
);
    logic [3:0] r_v;
    cabn_pkg::t_box r_b1, r_b2, r_b3, r_b4;
    logic [14:0] r_iw, r_ih;
    logic [29:0] r_area1, r_area2, r_inter2, r_inter3;
    logic [30:0] r_uni3;
    logic        r_sc1, r_sc2, r_sc3, r_sc4, r_nz4;
    logic [46:0] r_prod4;
    logic [45:0] r_lhs4;

    logic signed [16:0] ax0, ax1, bx0, bx1, ay0, ay1, by0, by1, lx, rx, ty, bt;
    logic signed [17:0] dx, dy;
    logic               sup;

    always_comb begin
        ax0 = 17'(i_cur.x);
        bx0 = 17'(i_box.x);
        ay0 = 17'(i_cur.y);
        by0 = 17'(i_box.y);
        ax1 = ax0 + $signed({2'b00, i_cur.w});
        bx1 = bx0 + $signed({2'b00, i_box.w});
        ay1 = ay0 + $signed({2'b00, i_cur.h});
        by1 = by0 + $signed({2'b00, i_box.h});
        lx  = (ax0 > bx0) ? ax0 : bx0;
        rx  = (ax1 < bx1) ? ax1 : bx1;
        ty  = (ay0 > by0) ? ay0 : by0;
        bt  = (ay1 < by1) ? ay1 : by1;
        dx  = 18'(rx) - 18'(lx);
        dy  = 18'(bt) - 18'(ty);
    end

    assign sup = r_sc4 && r_nz4 && ({1'b0, r_lhs4} > r_prod4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
        // stage 1: overlap extents and area of the chain box
        r_b1    <= i_box;
        r_iw    <= (dx > 0) ? dx[14:0] : 15'd0;
        r_ih    <= (dy > 0) ? dy[14:0] : 15'd0;
        r_area1 <= 30'(i_box.w) * 30'(i_box.h);
        r_sc1   <= (i_box.cls == i_cur.cls);
        // stage 2: intersection
        r_b2     <= r_b1;
        r_inter2 <= 30'(r_iw) * 30'(r_ih);
        r_area2  <= r_area1;
        r_sc2    <= r_sc1;
        // stage 3: union
        r_b3     <= r_b2;
        r_uni3   <= 31'(i_cur_area) + 31'(r_area2) - 31'(r_inter2);
        r_inter3 <= r_inter2;
        r_sc3    <= r_sc2;
        // stage 4: cross-multiplied compare operands
        r_b4    <= r_b3;
        r_prod4 <= 47'(i_thr) * 47'(r_uni3);
        r_lhs4  <= {r_inter3, 16'd0};
        r_nz4   <= (r_uni3 != 31'd0);
        r_sc4   <= r_sc3;
    end

    always_comb begin
        o_box      = r_b4;
        o_box.keep = r_b4.keep && !sup;
    end
    assign o_valid = r_v[3];
endmodule

>>> sv/class_aware_box_nms_unit.sv
// top level of the class-aware box nms unit: cell chain, iou pipe, control
// depends on cabn_pkg, cabn_cell, cabn_iou
//
// usage: boxes arrive one per accepted item (i_start high while o_busy low).
// each box is inserted into a chain of cells kept sorted by falling confidence;
// boxes past 64 are dropped and flagged as overflow.
// the item with last_box set ends the set and raises o_busy for the run.
// during the run the head of the chain is popped once per cycle, save while a pass
// waits for the iou pipe to drain; a kept head becomes the current box and every
// remaining box circulates once through the four-stage iou pipe and back to the
// chain tail.
// results appear on o_result for exactly one cycle with o_valid high, in rank
// order; the receiver cannot stall them. the last kept index carries last_kept.
// each result trails its kept head by one pass since last_kept is only known
// once the next kept box or the end of the chain is found.
// i_cfg_we writes the iou threshold; do so only while idle.
// synchronous active-low reset empties the set and sets the threshold to 29491.
module class_aware_box_nms_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  cabn_pkg::t_item   i_item,
    output logic              o_busy,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    output logic              o_valid,
    output cabn_pkg::t_result o_result
);
    typedef enum logic [1:0] {ST_LOAD, ST_HEAD, ST_PASS} t_state;

    t_state r_state;
    logic [cabn_pkg::CNT_W-1:0] r_occ, r_issue, occ_after;
    logic [15:0] r_thr;
    logic        r_ovf, r_pend_v, r_valid;
    logic [cabn_pkg::IDX_W-1:0] r_pend_idx;
    cabn_pkg::t_result r_result;
    cabn_pkg::t_box    r_cur;
    logic [29:0]       r_cur_area;

    cabn_pkg::t_cell_ctl ctl;
    cabn_pkg::t_box new_box, ret_box, head;
    cabn_pkg::t_box w_cell [cabn_pkg::MAX_BOXES];
    logic [cabn_pkg::MAX_BOXES-1:0] w_lt;
    logic accept, room, iss_v, ret_v;

    // boxes still inside the iou pipe
    logic u_iou_busy;
    logic [3:0] r_inflight;

    assign accept = (r_state == ST_LOAD) && i_start;
    assign room   = (r_occ < cabn_pkg::CNT_W'(cabn_pkg::MAX_BOXES));
    assign iss_v  = (r_state == ST_PASS) && (r_issue != '0);
    assign head   = w_cell[0];

    always_comb begin
        ctl.load  = accept && room;
        ctl.pop   = ((r_state == ST_HEAD) && (r_occ != '0)) || iss_v;
        ctl.push  = ret_v;
        occ_after = r_occ - cabn_pkg::CNT_W'(ctl.pop);
        new_box.x     = i_item.box_x;
        new_box.y     = i_item.box_y;
        new_box.w     = i_item.box_width;
        new_box.h     = i_item.box_height;
        new_box.score = i_item.confidence;
        new_box.cls   = i_item.class_id;
        new_box.idx   = r_occ[cabn_pkg::IDX_W-1:0];
        new_box.keep  = 1'b1;
    end

    for (genvar g = 0; g < cabn_pkg::MAX_BOXES; g++) begin : g_cell
        cabn_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_push_here (occ_after == cabn_pkg::CNT_W'(g)),
            .i_vacant    (cabn_pkg::CNT_W'(g) >= r_occ),
            .i_left_lt   ((g == 0) ? 1'b0 : w_lt[(g == 0) ? 0 : g-1]),
            .i_left      ((g == 0) ? new_box : w_cell[(g == 0) ? 0 : g-1]),
            .i_right     ((g == cabn_pkg::MAX_BOXES-1) ? new_box :
                          w_cell[(g == cabn_pkg::MAX_BOXES-1) ? g : g+1]),
            .i_new       (new_box),
            .i_ret       (ret_box),
            .o_box       (w_cell[g]),
            .o_lt        (w_lt[g])
        );
    end

    cabn_iou u_iou (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (iss_v),
        .i_box      (head),
        .i_cur      (r_cur),
        .i_cur_area (r_cur_area),
        .i_thr      (r_thr),
        .o_valid    (ret_v),
        .o_box      (ret_box)
    );

    always_ff @(posedge i_clk) begin
        r_cur_area <= 30'(r_cur.w) * 30'(r_cur.h);
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_occ    <= '0;
            r_issue  <= '0;
            r_thr    <= cabn_pkg::THR_RESET;
            r_ovf    <= 1'b0;
            r_pend_v <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_occ   <= occ_after + cabn_pkg::CNT_W'(ctl.push) + cabn_pkg::CNT_W'(ctl.load);
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            case (r_state)
                ST_LOAD: begin
                    if (accept) begin
                        if (!room) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_item.last_box) begin
                            r_state <= ST_HEAD;
                        end
                    end
                end
                ST_HEAD: begin
                    if (r_occ == '0) begin
                        // chain drained: flush the held index as the last one
                        r_valid              <= r_pend_v;
                        r_result.kept_index  <= r_pend_idx;
                        r_result.last_kept   <= 1'b1;
                        r_result.overflow    <= r_ovf;
                        r_pend_v             <= 1'b0;
                        r_ovf                <= 1'b0;
                        r_state              <= ST_LOAD;
                    end else if (head.keep) begin
                        r_valid              <= r_pend_v;
                        r_result.kept_index  <= r_pend_idx;
                        r_result.last_kept   <= 1'b0;
                        r_result.overflow    <= r_ovf;
                        r_pend_v             <= 1'b1;
                        r_pend_idx           <= head.idx;
                        r_cur                <= head;
                        r_issue              <= r_occ - cabn_pkg::CNT_W'(1);
                        r_state              <= ST_PASS;
                    end
                end
                ST_PASS: begin
                    if (iss_v) begin
                        r_issue <= r_issue - cabn_pkg::CNT_W'(1);
                    end else if (!ret_v && !u_iou_busy) begin
                        r_state <= ST_HEAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign u_iou_busy = (r_inflight != 4'd0);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 4'd0;
        end else begin
            r_inflight <= r_inflight + 4'(iss_v) - 4'(ret_v);
        end
    end

    assign o_busy   = (r_state != ST_LOAD);
    assign o_valid  = r_valid;
    assign o_result = r_result;

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= cabn_pkg::CNT_W'(cabn_pkg::MAX_BOXES))
        else $error("chain occupancy above capacity");
    a_pipe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 4'd4)
        else $error("iou pipe holds more than its depth");
    a_last_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.last_kept |=> !o_valid)
        else $error("result after last kept index");
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOAD |-> !r_pend_v && r_inflight == 4'd0)
        else $error("run state left over while idle");
`endif
endmodule
